// ===== hdl/bads_pkg.sv =====
// shared constants and types for the 2x2 box average downscaler
`default_nettype none
package bads_pkg;

  // line store sizing
  localparam int MAX_WIDTH  = 4096;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int IDX_W      = $clog2(LINE_DEPTH);

  // field widths
  localparam int CHAN_W   = 8;
  localparam int SUM_W    = CHAN_W + 1;
  localparam int LINE_W   = 3 * SUM_W;
  localparam int FWIDTH_W = 13;
  localparam int HEIGHT_W = 16;
  localparam int CFG_W    = 16;

  // configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // reset values of the frame size registers
  localparam logic [FWIDTH_W-1:0] FRAME_WIDTH_RESET  = FWIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RESET = HEIGHT_W'(480);

  // per-request controls fanned out to every channel cell
  typedef struct packed {
    logic hold_en;
    logic s1_load;
    logic out_load;
  } lane_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/bads_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none
module bads_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bads_lane.sv =====
// one color channel cell: held left pixel, pair sum and block average
`default_nettype none
module bads_lane (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire bads_pkg::lane_ctrl_t       ctrl,
  input  wire logic [bads_pkg::CHAN_W-1:0] pixel,
  input  wire logic [bads_pkg::SUM_W-1:0]  top_sum,
  output logic      [bads_pkg::SUM_W-1:0]  pair_sum,
  output logic      [bads_pkg::CHAN_W-1:0] avg
);
  import bads_pkg::*;

  logic [CHAN_W-1:0] held;
  logic [SUM_W-1:0]  pair_s1;
  logic [SUM_W:0]    block_sum;

  // horizontal pair sum of held left pixel and current pixel
  assign pair_sum = SUM_W'(held) + SUM_W'(pixel);

  // full 2x2 sum from the staged pair and the line store entry
  assign block_sum = (SUM_W + 1)'(pair_s1) + (SUM_W + 1)'(top_sum);

  // held left pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (ctrl.hold_en) begin
      held <= pixel;
    end
  end

  // pair sum waits here for the line store read
  always_ff @(posedge clk) begin
    if (ctrl.s1_load) begin
      pair_s1 <= pair_sum;
    end
  end

  // truncated average into the output register
  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      avg <= block_sum[SUM_W:2];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/box_average_downscale_2x.sv =====
// top level of the 2x2 box average downscaler
// a block result enters the wait stage with its last pixel request, then the output register
// throughput: one pixel request per cycle, sustained while results are taken
// the line store read is registered, so a block sum waits one stage for it
// reset: counters and held pixels clear, frame size returns to 640 x 480
// the line store has no reset; every entry is written on an even row before use
`default_nettype none
module box_average_downscale_2x (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [bads_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [bads_pkg::CHAN_W-1:0]   red_in,
  input  wire logic [bads_pkg::CHAN_W-1:0]   green_in,
  input  wire logic [bads_pkg::CHAN_W-1:0]   blue_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [bads_pkg::CHAN_W-1:0]   red_out,
  output logic      [bads_pkg::CHAN_W-1:0]   green_out,
  output logic      [bads_pkg::CHAN_W-1:0]   blue_out,
  output logic                               frame_end
);
  import bads_pkg::*;

  logic [FWIDTH_W-1:0] frame_width;
  logic [HEIGHT_W-1:0] frame_height;
  logic [COL_W-1:0]    column_count;
  logic [HEIGHT_W-1:0] row_count;
  logic                s1_valid;
  logic                s1_end;

  logic [COL_W:0]      w_eff;
  logic [HEIGHT_W:0]   h_eff;
  logic [COL_W:0]      last_c;
  logic [HEIGHT_W:0]   last_r;
  logic [COL_W:0]      col_plus;
  logic [HEIGHT_W:0]   row_plus;
  logic                accept;
  logic                emit;
  logic                line_wr;
  logic                is_end;
  logic                out_free;
  logic                s1_move;
  logic [IDX_W-1:0]    line_idx;
  lane_ctrl_t          ctrl;
  logic [LINE_W-1:0]   line_wr_data;
  logic [LINE_W-1:0]   line_rd_data;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FWIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size, zero or oversize width acts as the maximum
  assign w_eff = (frame_width == '0 || 32'(frame_width) > MAX_WIDTH) ?
                 (COL_W + 1)'(MAX_WIDTH) : (COL_W + 1)'(frame_width);
  assign h_eff = (frame_height == '0) ? {1'b1, {HEIGHT_W{1'b0}}} : {1'b0, frame_height};

  // handshake: output register and one wait stage
  assign out_free = !out_valid || out_ready;
  assign s1_move  = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;
  assign accept   = in_valid && in_ready;

  // request classification by position
  assign emit     = accept && column_count[0] && row_count[0];
  assign line_wr  = accept && column_count[0] && !row_count[0];
  assign line_idx = column_count[COL_W-1:1];

  // last block position of the frame
  assign last_c = {w_eff[COL_W:1], 1'b0} - 1'b1;
  assign last_r = {h_eff[HEIGHT_W:1], 1'b0} - 1'b1;
  assign is_end = (w_eff >= (COL_W + 1)'(2)) && (h_eff >= (HEIGHT_W + 1)'(2)) &&
                  ({1'b0, column_count} == last_c) && ({1'b0, row_count} == last_r);

  // raster position counters
  assign col_plus = {1'b0, column_count} + 1'b1;
  assign row_plus = {1'b0, row_count} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_plus >= w_eff) begin
        column_count <= '0;
        if (row_plus >= h_eff) begin
          row_count <= '0;
        end else begin
          row_count <= row_plus[HEIGHT_W-1:0];
        end
      end else begin
        column_count <= col_plus[COL_W-1:0];
      end
    end
  end

  // wait stage and output valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // frame end flag travels with the block
  always_ff @(posedge clk) begin
    if (emit) begin
      s1_end <= is_end;
    end
    if (s1_move) begin
      frame_end <= s1_end;
    end
  end

  // controls shared by the channel cells
  assign ctrl.hold_en  = accept && !column_count[0];
  assign ctrl.s1_load  = emit;
  assign ctrl.out_load = s1_move;

  // channel cells
  bads_lane u_lane_red (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .pixel    (red_in),
    .top_sum  (line_rd_data[3*SUM_W-1:2*SUM_W]),
    .pair_sum (line_wr_data[3*SUM_W-1:2*SUM_W]),
    .avg      (red_out)
  );

  bads_lane u_lane_green (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .pixel    (green_in),
    .top_sum  (line_rd_data[2*SUM_W-1:SUM_W]),
    .pair_sum (line_wr_data[2*SUM_W-1:SUM_W]),
    .avg      (green_out)
  );

  bads_lane u_lane_blue (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .pixel    (blue_in),
    .top_sum  (line_rd_data[SUM_W-1:0]),
    .pair_sum (line_wr_data[SUM_W-1:0]),
    .avg      (blue_out)
  );

  // line store of even row pair sums
  bads_ram #(
    .WIDTH (LINE_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (line_wr),
    .wr_addr (line_idx),
    .wr_data (line_wr_data),
    .rd_en   (emit),
    .rd_addr (line_idx),
    .rd_data (line_rd_data)
  );

endmodule
`default_nettype wire
